// ===== design/token_pair_hash_counter_core_assert.svh =====
// Assertion macros shared by the token pair hash counter RTL.
`ifndef TOKEN_PAIR_HASH_COUNTER_CORE_ASSERT_SVH
`define TOKEN_PAIR_HASH_COUNTER_CORE_ASSERT_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define TPHC_CHK_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk outside reset.
`define TPHC_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tphc_pkg.sv =====
// Shared types and constants for the token pair hash counter.
package tphc_pkg;

    // FNV-1a 32-bit offset basis
    localparam logic [31:0] FNV_BASIS    = 32'h811C_9DC5;
    // FNV prime is 2^24 + 403; the low part is multiplied, the high part shifted
    localparam int          FNV_SHIFT    = 24;
    localparam logic [8:0]  FNV_PRIME_LO = 9'd403;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_CHECK,
        S_WALK,
        S_MISS,
        S_RESULT
    } t_state;

endpackage

// ===== design/tphc_pair_if.sv =====
// Input channel carrying one token pair per transfer.
interface tphc_pair_if;
    logic        valid;
    logic        ready;
    logic [31:0] first_token;
    logic [31:0] second_token;

    modport source (output valid, output first_token, output second_token, input ready);
    modport sink   (input valid, input first_token, input second_token, output ready);
endinterface

// ===== design/tphc_count_if.sv =====
// Output channel carrying one count result per transfer.
interface tphc_count_if;
    logic        valid;
    logic        ready;
    logic [31:0] pair_count;
    logic        was_new;
    logic        dropped;

    modport source (output valid, output pair_count, output was_new, output dropped,
                    input ready);
    modport sink   (input valid, input pair_count, input was_new, input dropped,
                    output ready);
endinterface

// ===== design/tphc_hash.sv =====
// Iterative FNV-1a hash of a token pair, reduced to a bucket index.
module tphc_hash
    import tphc_pkg::*;
#(
    parameter int NUM_BUCKETS = 1024,
    parameter int BKW         = $clog2(NUM_BUCKETS)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [31:0]    i_first,
    input  logic [31:0]    i_second,
    output logic           o_done,
    output logic [BKW-1:0] o_bucket
);

    localparam bit BK_POW2   = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);
    // steps 0 and 1 mix the two words; otherwise a multiply step and a remainder step
    localparam int LAST_STEP = BK_POW2 ? 1 : 3;

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_step;
    logic [31:0] r_h;

    logic [31:0] w_src;
    logic [31:0] w_word;
    logic [31:0] w_x;
    logic [40:0] w_prod;
    logic [31:0] w_mix;
    logic        w_mixing;

    // shared mix unit: h = (h ^ w) * prime, mod 2^32
    assign w_mixing = r_busy && (r_step[5:1] == 5'd0);
    assign w_src    = (r_step == 6'd0) ? FNV_BASIS : r_h;
    assign w_word   = (r_step == 6'd0) ? i_first : i_second;
    assign w_x      = w_src ^ w_word;
    assign w_prod   = 41'(w_x) * 41'(FNV_PRIME_LO);
    assign w_mix    = {w_x[31-FNV_SHIFT:0], {FNV_SHIFT{1'b0}}} + w_prod[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 6'd1;
                if (r_step == 6'(LAST_STEP)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // hash word, mixed in steps 0 and 1, then held
    always_ff @(posedge i_clk) begin
        if (w_mixing) begin
            r_h <= w_mix;
        end
    end

    generate
        if (BK_POW2) begin : g_mask
            assign o_bucket = r_h[BKW-1:0];
        end else begin : g_rem
            // floor(h / N) = (h * RMUL) >> RSH for every 32-bit h
            localparam int          RSH  = 32 + BKW;
            localparam logic [63:0] RMUL = ((64'd1 << RSH) + 64'(NUM_BUCKETS) - 64'd1)
                                           / 64'(NUM_BUCKETS);

            logic [64:0]    r_prod;
            logic [31:0]    w_quo;
            logic [BKW-1:0] r_rem;

            assign w_quo = 32'(r_prod >> RSH);

            // step 2: reciprocal product; step 3: h - q * N
            always_ff @(posedge i_clk) begin
                if (r_busy) begin
                    if (r_step == 6'd2) begin
                        r_prod <= 65'(r_h) * 65'(RMUL[32:0]);
                    end else if (r_step == 6'd3) begin
                        r_rem <= BKW'(r_h - w_quo * 32'(NUM_BUCKETS));
                    end
                end
            end

            assign o_bucket = r_rem;
        end
    endgenerate

    assign o_done = r_done;

endmodule

// ===== design/token_pair_hash_counter_core.sv =====
// Top level: token pair counter over a chained hash table with a fixed entry pool.
//
//  channel   | dir | payload                              | transfer when
//  ----------+-----+--------------------------------------+------------------
//  i_pair    | in  | first_token, second_token            | valid && ready
//  o_count   | out | pair_count, was_new, dropped         | valid && ready
//
//  After reset the bucket head memory is cleared, one bucket per cycle,
//  while i_pair.ready stays low. A pair passes the shared hash unit (two
//  mix steps, plus a reciprocal multiply and a remainder step when
//  NUM_BUCKETS is not a power of two), a bucket head read and the
//  one-entry-per-cycle chain walk through the entry memory; a miss or drop
//  adds the miss state before the result. The next pair can transfer at the
//  end of the first cycle in which the result is shown.
//  One pair is in flight at a time. A finished result sits in the output
//  register; the next pair is taken while it waits, and stalls only at its
//  own result stage if the previous result is still not taken.
module token_pair_hash_counter_core
    import tphc_pkg::*;
#(
    parameter int NUM_BUCKETS    = 1024,
    parameter int ENTRY_CAPACITY = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tphc_pair_if.sink    i_pair,
    tphc_count_if.source o_count
);

    `include "token_pair_hash_counter_core_assert.svh"

    localparam int BKW = $clog2(NUM_BUCKETS);
    // pointers hold entry index + 1, zero is nil
    localparam int PW  = $clog2(ENTRY_CAPACITY + 1);
    localparam int EW  = $clog2(ENTRY_CAPACITY);

    t_state r_state;
    t_state n_state;

    // control state
    logic [BKW-1:0] r_clr;
    logic [PW-1:0]  r_used;
    logic           r_out_valid;

    // item datapath
    logic [31:0]    r_a;
    logic [31:0]    r_b;
    logic [BKW-1:0] r_bk;
    logic [PW-1:0]  r_cur;
    logic [PW-1:0]  r_head;
    logic [31:0]    r_res_cnt;
    logic           r_res_new;
    logic           r_res_drop;
    logic [31:0]    r_out_cnt;
    logic           r_out_new;
    logic           r_out_drop;

    // memories and their registered read data
    logic [PW-1:0]  m_head   [NUM_BUCKETS];
    logic [31:0]    m_first  [ENTRY_CAPACITY];
    logic [31:0]    m_second [ENTRY_CAPACITY];
    logic [31:0]    m_tally  [ENTRY_CAPACITY];
    logic [PW-1:0]  m_link   [ENTRY_CAPACITY];
    logic [PW-1:0]  r_head_q;
    logic [31:0]    r_e_first;
    logic [31:0]    r_e_second;
    logic [31:0]    r_e_tally;
    logic [PW-1:0]  r_e_link;

    logic           w_accept;
    logic           w_hash_done;
    logic [BKW-1:0] w_hash_bucket;
    logic           w_full;
    logic           w_hit;
    logic [31:0]    w_tally_inc;
    logic [PW-1:0]  w_next_ptr;
    logic           w_ptr_ok;
    logic           w_out_free;

    // controls decoded from state
    logic           w_in_ready;
    logic           w_head_re;
    logic           w_head_we;
    logic [BKW-1:0] w_head_waddr;
    logic [PW-1:0]  w_head_wdata;
    logic           w_ent_re;
    logic [EW-1:0]  w_ent_raddr;
    logic           w_key_we;
    logic           w_tally_we;
    logic [EW-1:0]  w_ent_waddr;
    logic [31:0]    w_tally_wdata;
    logic           w_out_load;

    tphc_hash #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .BKW         (BKW)
    ) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept),
        .i_first  (r_a),
        .i_second (r_b),
        .o_done   (w_hash_done),
        .o_bucket (w_hash_bucket)
    );

    assign w_accept    = i_pair.valid && w_in_ready;
    assign w_full      = (r_used == PW'(ENTRY_CAPACITY));
    assign w_hit       = (r_e_first == r_a) && (r_e_second == r_b);
    // tally saturates at all ones
    assign w_tally_inc = (&r_e_tally) ? r_e_tally : r_e_tally + 32'd1;
    // next chain pointer: the bucket head on the first look, then the link
    assign w_next_ptr  = (r_state == S_CHECK) ? r_head_q : r_e_link;
    // nil or beyond the allocated entries ends the walk
    assign w_ptr_ok    = (w_next_ptr != '0) && (w_next_ptr <= r_used);
    assign w_out_free  = !r_out_valid || o_count.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == BKW'(NUM_BUCKETS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_pair.valid) n_state = S_HASH;
            end
            S_HASH: begin
                if (w_hash_done) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = w_ptr_ok ? S_WALK : S_MISS;
            end
            S_WALK: begin
                if (w_hit)          n_state = S_RESULT;
                else if (!w_ptr_ok) n_state = S_MISS;
            end
            S_MISS: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        w_in_ready    = 1'b0;
        w_head_re     = 1'b0;
        w_head_we     = 1'b0;
        w_head_waddr  = r_bk;
        w_head_wdata  = r_used + PW'(1);
        w_ent_re      = 1'b0;
        w_ent_raddr   = EW'(w_next_ptr - PW'(1));
        w_key_we      = 1'b0;
        w_tally_we    = 1'b0;
        w_ent_waddr   = EW'(r_used);
        w_tally_wdata = 32'd1;
        w_out_load    = 1'b0;
        case (r_state)
            S_CLEAR: begin
                w_head_we    = 1'b1;
                w_head_waddr = r_clr;
                w_head_wdata = '0;
            end
            S_IDLE: begin
                w_in_ready = 1'b1;
            end
            S_HASH: begin
                w_head_re = w_hash_done;
            end
            S_CHECK: begin
                w_ent_re = w_ptr_ok;
            end
            S_WALK: begin
                if (w_hit) begin
                    w_tally_we    = 1'b1;
                    w_ent_waddr   = EW'(r_cur - PW'(1));
                    w_tally_wdata = w_tally_inc;
                end else begin
                    w_ent_re = w_ptr_ok;
                end
            end
            S_MISS: begin
                w_head_we  = !w_full;
                w_key_we   = !w_full;
                w_tally_we = !w_full;
            end
            S_RESULT: begin
                w_out_load = w_out_free;
            end
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + BKW'(1);
            if (w_key_we) r_used <= r_used + PW'(1);
            if (w_out_load)         r_out_valid <= 1'b1;
            else if (o_count.ready) r_out_valid <= 1'b0;
        end
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a <= i_pair.first_token;
            r_b <= i_pair.second_token;
        end
        if (w_head_re) r_bk <= w_hash_bucket;
        if (r_state == S_CHECK) r_head <= r_head_q;
        if (w_ent_re) r_cur <= w_next_ptr;
        if ((r_state == S_WALK) && w_hit) begin
            r_res_cnt  <= w_tally_inc;
            r_res_new  <= 1'b0;
            r_res_drop <= 1'b0;
        end else if (r_state == S_MISS) begin
            // pool full: drop the pair and leave the table alone
            r_res_cnt  <= w_full ? 32'd0 : 32'd1;
            r_res_new  <= !w_full;
            r_res_drop <= w_full;
        end
        if (w_out_load) begin
            r_out_cnt  <= r_res_cnt;
            r_out_new  <= r_res_new;
            r_out_drop <= r_res_drop;
        end
    end

    // bucket heads
    always_ff @(posedge i_clk) begin
        if (w_head_we) m_head[w_head_waddr] <= w_head_wdata;
        if (w_head_re) r_head_q <= m_head[w_hash_bucket];
    end

    // entry pool; a new entry links to the old chain head
    always_ff @(posedge i_clk) begin
        if (w_key_we) begin
            m_first[w_ent_waddr]  <= r_a;
            m_second[w_ent_waddr] <= r_b;
            m_link[w_ent_waddr]   <= r_head;
        end
        if (w_tally_we) m_tally[w_ent_waddr] <= w_tally_wdata;
        if (w_ent_re) begin
            r_e_first  <= m_first[w_ent_raddr];
            r_e_second <= m_second[w_ent_raddr];
            r_e_tally  <= m_tally[w_ent_raddr];
            r_e_link   <= m_link[w_ent_raddr];
        end
    end

    assign i_pair.ready       = w_in_ready;
    assign o_count.valid      = r_out_valid;
    assign o_count.pair_count = r_out_cnt;
    assign o_count.was_new    = r_out_new;
    assign o_count.dropped    = r_out_drop;

    `TPHC_CHK_IMPLY(a_used_bound, 1'b1, r_used <= PW'(ENTRY_CAPACITY), "pool count past capacity")
    `TPHC_CHK_NEXT(a_used_only_on_miss, r_state != S_MISS, $stable(r_used), "pool count moved outside a miss")
    `TPHC_CHK_IMPLY(a_walk_in_pool, r_state == S_WALK, (r_cur != '0) && (r_cur <= r_used), "walk left the allocated entries")
    `TPHC_CHK_IMPLY(a_hash_done_state, w_hash_done, r_state == S_HASH, "hash finished outside the hash state")

endmodule

// ===== dv/tphc_tally_check.sv =====
// Pair count checker: watches both channels, predicts each count and compares the results.
module tphc_tally_check #(
    parameter int ENTRY_CAPACITY = 1024
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tphc_pair_if  i_pair_mon,
    tphc_count_if i_count_mon,
    output int    o_fail_count,
    output int    o_pending
);

    typedef struct packed {
        logic [31:0] pair_count;
        logic        was_new;
        logic        dropped;
    } t_count_result;

    localparam logic [31:0] TALLY_MAX   = '1;

    // pool contents seen from outside: key {first, second} -> tally
    logic [31:0]   tally_by_pair [logic [63:0]];
    int unsigned   pool_used = 0;
    t_count_result counts_due [$];
    int            fails     = 0;
    int            pending   = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending;

    function automatic t_count_result tally_pair(input logic [31:0] first_tok,
                                                 input logic [31:0] second_tok);
        t_count_result res;
        logic [63:0]   key;
        key = {first_tok, second_tok};
        res = '0;
        if (tally_by_pair.exists(key)) begin
            if (tally_by_pair[key] != TALLY_MAX) begin
                tally_by_pair[key] = tally_by_pair[key] + 32'd1;
            end
            res.pair_count = tally_by_pair[key];
        end else if (pool_used >= ENTRY_CAPACITY) begin
            // pool exhausted: pair is dropped, nothing changes
            res.dropped = 1'b1;
        end else begin
            tally_by_pair[key] = 32'd1;
            pool_used++;
            res.pair_count = 32'd1;
            res.was_new    = 1'b1;
        end
        return res;
    endfunction

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        fails++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin : watch
        t_count_result want;
        if (i_rst_n) begin
            if (i_pair_mon.valid && i_pair_mon.ready) begin
                counts_due.push_back(tally_pair(i_pair_mon.first_token,
                                                i_pair_mon.second_token));
            end
            if (i_count_mon.valid && i_count_mon.ready) begin
                if (counts_due.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result, expected none, actual count %0d new %0b dropped %0b",
                             $time, i_count_mon.pair_count, i_count_mon.was_new,
                             i_count_mon.dropped);
                end else begin
                    want = counts_due.pop_front();
                    if (i_count_mon.pair_count !== want.pair_count)
                        note_mismatch("pair_count", want.pair_count, i_count_mon.pair_count);
                    if (i_count_mon.was_new !== want.was_new)
                        note_mismatch("was_new", 32'(want.was_new), 32'(i_count_mon.was_new));
                    if (i_count_mon.dropped !== want.dropped)
                        note_mismatch("dropped", 32'(want.dropped), 32'(i_count_mon.dropped));
                end
            end
            pending = counts_due.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
// Testbench top: drives token pairs into the hash counter and gives the verdict.
module testbench;
    import tphc_pkg::*;

    localparam int          NUM_BUCKETS    = 1024;
    localparam int          ENTRY_CAPACITY = 1024;
    localparam int          RANDOM_PAIRS   = 1230;
    localparam int          GAP_MAX        = 18;
    localparam int          DRAIN_CYCLES   = 400;
    localparam logic [31:0] FNV_MULT       = 32'd16777619;

    logic        i_clk;
    logic        i_rst_n;
    int          fail_count;
    int          pending_count;
    logic [63:0] sent_pairs [$];
    bit          seen_pair [logic [63:0]];
    bit          tx_quiet;
    bit          rx_quiet;
    int          rx_hold;
    int unsigned hot_bucket;

    tphc_pair_if  pair_ch ();
    tphc_count_if count_ch ();

    token_pair_hash_counter_core #(
        .NUM_BUCKETS   (NUM_BUCKETS),
        .ENTRY_CAPACITY(ENTRY_CAPACITY)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pair (pair_ch),
        .o_count(count_ch)
    );

    tphc_tally_check #(
        .ENTRY_CAPACITY(ENTRY_CAPACITY)
    ) tally_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pair_mon  (pair_ch),
        .i_count_mon (count_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending_count)
    );

    always #5 i_clk = ~i_clk;

    // Bucket index of a pair; only used to steer pairs into chosen chains.
    function automatic int unsigned bucket_of_pair(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] h;
        h = FNV_BASIS;
        h = (h ^ a) * FNV_MULT;
        h = (h ^ b) * FNV_MULT;
        return h % NUM_BUCKETS;
    endfunction

    function automatic int draw_gap(input bit quiet);
        return quiet ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    function automatic logic [31:0] pick_token();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 15);
            3: return 32'd1 << $urandom_range(0, 31);
            4: return ~(32'd1 << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    // Called at a clock edge; returns at the edge of the transfer. valid is only
    // lowered when a gap follows, so back-to-back pairs keep it high.
    task automatic send_pair(input logic [31:0] a, input logic [31:0] b);
        int          gap;
        logic [63:0] key;
        key = {a, b};
        if (!seen_pair.exists(key)) begin
            seen_pair[key] = 1'b1;
            sent_pairs.push_back(key);
        end
        if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
        gap = draw_gap(tx_quiet);
        if (gap > 0) begin
            pair_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pair_ch.valid        <= 1'b1;
        pair_ch.first_token  <= a;
        pair_ch.second_token <= b;
        @(posedge i_clk);
        while (!pair_ch.ready) @(posedge i_clk);
    endtask

    // Searches a second token that lands the pair in the given bucket,
    // which grows that chain.
    task automatic send_colliding(input int unsigned target);
        logic [31:0] a;
        logic [31:0] b;
        int          tries;
        a     = pick_token();
        b     = $urandom;
        tries = 0;
        while (bucket_of_pair(a, b) != target && tries < 20000) begin
            b = $urandom;
            tries++;
        end
        send_pair(a, b);
    endtask

    // Result side: after a transfer, ready may drop for a random gap, none while the side is quiet.
    always @(posedge i_clk) begin : rx_side
        int gap;
        if (!i_rst_n) begin
            count_ch.ready <= 1'b0;
            rx_hold        <= 0;
        end else begin
            if ($urandom_range(0, 39) == 0) rx_quiet <= !rx_quiet;
            if (count_ch.valid && count_ch.ready) begin
                gap = draw_gap(rx_quiet);
                if (gap > 0) begin
                    count_ch.ready <= 1'b0;
                    rx_hold        <= gap;
                end
            end else if (!count_ch.ready) begin
                if (rx_hold <= 1) count_ch.ready <= 1'b1;
                rx_hold <= rx_hold - 1;
            end
        end
    end

    initial begin : stimulus
        int          roll;
        bit          pool_full;
        logic [63:0] key;
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        pair_ch.valid        = 1'b0;
        pair_ch.first_token  = '0;
        pair_ch.second_token = '0;
        tx_quiet             = 1'b0;
        hot_bucket           = bucket_of_pair('0, '0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // field extremes, first hits, swapped-order pairs
        send_pair('0, '0);
        send_pair('0, '0);
        send_pair('1, '1);
        send_pair('0, '1);
        send_pair('1, '0);
        send_pair('0, '1);
        send_pair('1, '1);
        send_pair(32'd1, 32'd0);
        send_pair(32'd0, 32'd1);
        send_pair(32'h8000_0000, 32'h0000_0001);
        // pile pairs onto one chain so that older entries sit deep
        repeat (6) send_colliding(hot_bucket);
        send_pair('0, '0);
        key = sent_pairs[7];
        send_pair(key[63:32], key[31:0]);
        send_pair('0, '0);

        // mostly fresh pairs until the pool fills, then hits mixed with drops
        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            roll      = $urandom_range(0, 99);
            pool_full = sent_pairs.size() >= ENTRY_CAPACITY;
            if (roll < (pool_full ? 55 : 10)) begin
                key = sent_pairs[$urandom_range(0, sent_pairs.size() - 1)];
                send_pair(key[63:32], key[31:0]);
            end else if (roll < (pool_full ? 65 : 22)) begin
                if ($urandom_range(0, 1) == 0) begin
                    send_colliding(hot_bucket);
                end else begin
                    key = sent_pairs[$urandom_range(0, sent_pairs.size() - 1)];
                    send_colliding(bucket_of_pair(key[63:32], key[31:0]));
                end
            end else begin
                send_pair(pick_token(), pick_token());
            end
        end
        pair_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("[token_pair_hash_counter_core] OK");
        end else begin
            $display("[token_pair_hash_counter_core] ERROR");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin : watchdog
        #10_000_000;
        $display("[token_pair_hash_counter_core] ERROR");
        $finish;
    end

endmodule
